>>> src/pds_pkg.sv
// shared types and constants for the pll divider search block
// no dependencies; imported by every module of the block
package pds_pkg;

  // search ranges
  localparam int FEEDBACK_MIN = 16;
  localparam int FEEDBACK_MAX = 320;
  localparam int POST_DIV_MAX = 7;
  localparam int ERROR_BOUND  = 100000;

  // fixed port widths
  localparam int REF_W   = 16;
  localparam int KHZ_W   = 24;
  localparam int FBO_W   = 9;
  localparam int PDO_W   = 3;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 2;

  // internal widths derived from the ranges
  localparam int FB_W    = $clog2(FEEDBACK_MAX + 1);
  localparam int PD_W    = $clog2(POST_DIV_MAX + 1);
  localparam int DIV_W   = $clog2(POST_DIV_MAX * POST_DIV_MAX + 1);
  localparam int VCO_W   = REF_W + FB_W;
  localparam int STEP_W  = $clog2(VCO_W);
  localparam int ERR_W   = $clog2(ERROR_BOUND + 1);

  // register reset values
  localparam logic [REF_W-1:0] REF_KHZ_RESET = REF_W'(12000);
  localparam logic [KHZ_W-1:0] VCO_MIN_RESET = KHZ_W'(400000);
  localparam logic [KHZ_W-1:0] VCO_MAX_RESET = KHZ_W'(1600000);

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_REF_KHZ   = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_VCO_MIN   = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] CFG_VCO_MAX   = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] CFG_PREFER_LO = CIDX_W'(3);

  typedef struct packed {
    logic [REF_W-1:0] ref_khz;
    logic [KHZ_W-1:0] vco_min_khz;
    logic [KHZ_W-1:0] vco_max_khz;
    logic             prefer_low_vco;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [VCO_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VCO_W-1:0] quotient;
    logic             rem_zero;
  } div_rsp_t;

  typedef struct packed {
    logic             found;
    logic             exact;
    logic [KHZ_W-1:0] achieved_khz;
    logic [KHZ_W-1:0] chosen_vco_khz;
    logic [FBO_W-1:0] chosen_feedback;
    logic [PDO_W-1:0] chosen_post1;
    logic [PDO_W-1:0] chosen_post2;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_WAIT,
    S_NEXT,
    S_DONE
  } search_state_t;

endpackage

>>> src/pds_divider.sv
// bit-serial restoring divider: vco by post divider product, one quotient bit per cycle
// depends on pds_pkg
module pds_divider (
  input  logic              clk,
  input  logic              rst,
  input  pds_pkg::div_req_t req,
  output pds_pkg::div_rsp_t rsp
);
  import pds_pkg::*;

  logic              running;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [VCO_W-1:0]  dvd;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W:0]    trial;
  logic              ge;
  logic [DIV_W-1:0]  rem_next;

  // shift in next dividend bit, subtract if it fits
  assign trial    = {rem, dvd[VCO_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign rem_next = ge ? DIV_W'(trial - {1'b0, dsr}) : DIV_W'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        if (step == STEP_W'(VCO_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

  // quotient bits replace dividend bits in the same register
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (running) begin
      dvd <= {dvd[VCO_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;
  assign rsp.rem_zero = (rem == '0);

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !running)
    else $error("divider started while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    running |-> rem < dsr)
    else $error("partial remainder not below divisor");
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running))
    else $error("divider done without a run");
`endif

endmodule

>>> src/pds_search.sv
// search sequencer: walks feedback and post divider settings, keeps the best candidate
// depends on pds_pkg and pds_divider
module pds_search (
  input  logic                     clk,
  input  logic                     rst,
  input  pds_pkg::cfg_t            cfg,
  input  logic                     start,
  input  logic [pds_pkg::KHZ_W-1:0] request,
  output logic                     busy,
  output logic                     res_valid,
  input  logic                     res_ready,
  output pds_pkg::result_t         res
);
  import pds_pkg::*;

  search_state_t     state;
  search_state_t     state_next;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [KHZ_W-1:0]  req;
  logic [FB_W-1:0]   fb;
  logic [VCO_W-1:0]  vco;
  logic [PD_W-1:0]   p1;
  logic [PD_W-1:0]   p2;

  logic              found;
  logic [ERR_W-1:0]  best_err;
  logic [VCO_W-1:0]  best_khz;
  logic [VCO_W-1:0]  best_vco;
  logic [FB_W-1:0]   best_fb;
  logic [PD_W-1:0]   best_p1;
  logic [PD_W-1:0]   best_p2;
  logic              best_rem_zero;

  logic              in_win;
  logic              fb_last;
  logic              pair_last;
  logic [VCO_W-1:0]  req_ext;
  logic [VCO_W-1:0]  err;
  logic              better;
  logic [FB_W-1:0]   fb_first;

  pds_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign fb_first  = cfg.prefer_low_vco ? FB_W'(FEEDBACK_MIN) : FB_W'(FEEDBACK_MAX);
  assign in_win    = (vco >= {1'b0, cfg.vco_min_khz}) && (vco <= {1'b0, cfg.vco_max_khz});
  assign fb_last   = cfg.prefer_low_vco ? (fb == FB_W'(FEEDBACK_MAX))
                                        : (fb == FB_W'(FEEDBACK_MIN));
  assign pair_last = (p1 == PD_W'(1)) && (p2 == PD_W'(1));
  assign req_ext   = VCO_W'(req);
  assign err       = (div_rsp.quotient >= req_ext) ? div_rsp.quotient - req_ext
                                                   : req_ext - div_rsp.quotient;
  assign better    = err < VCO_W'(best_err);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_CHECK;
      S_CHECK: state_next = in_win ? S_DIV : S_NEXT;
      S_DIV:   state_next = S_WAIT;
      S_WAIT:  if (div_rsp.done) state_next = pair_last ? S_NEXT : S_DIV;
      S_NEXT:  state_next = fb_last ? S_DONE : S_CHECK;
      S_DONE:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy             = (state != S_IDLE);
    res_valid        = (state == S_DONE);
    div_req.start    = (state == S_DIV);
    div_req.dividend = vco;
    div_req.divisor  = DIV_W'(DIV_W'(p1) * DIV_W'(p2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          req           <= request;
          fb            <= fb_first;
          vco           <= VCO_W'(cfg.ref_khz) * VCO_W'(fb_first);
          found         <= 1'b0;
          best_err      <= ERR_W'(ERROR_BOUND);
          best_khz      <= '0;
          best_vco      <= '0;
          best_fb       <= '0;
          best_p1       <= '0;
          best_p2       <= '0;
          best_rem_zero <= 1'b0;
        end
      end
      S_CHECK: begin
        p1 <= PD_W'(POST_DIV_MAX);
        p2 <= PD_W'(POST_DIV_MAX);
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (better) begin
            found         <= 1'b1;
            best_err      <= ERR_W'(err);
            best_khz      <= div_rsp.quotient;
            best_vco      <= vco;
            best_fb       <= fb;
            best_p1       <= p1;
            best_p2       <= p2;
            best_rem_zero <= div_rsp.rem_zero;
          end
          if (p2 == PD_W'(1)) begin
            p1 <= p1 - PD_W'(1);
            p2 <= p1 - PD_W'(1);
          end else begin
            p2 <= p2 - PD_W'(1);
          end
        end
      end
      S_NEXT: begin
        if (!fb_last) begin
          if (cfg.prefer_low_vco) begin
            fb  <= fb + FB_W'(1);
            vco <= vco + VCO_W'(cfg.ref_khz);
          end else begin
            fb  <= fb - FB_W'(1);
            vco <= vco - VCO_W'(cfg.ref_khz);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.found           = found;
    res.exact           = found && (best_khz == req_ext) && best_rem_zero;
    res.achieved_khz    = KHZ_W'(best_khz);
    res.chosen_vco_khz  = KHZ_W'(best_vco);
    res.chosen_feedback = FBO_W'(best_fb);
    res.chosen_post1    = PDO_W'(best_p1);
    res.chosen_post2    = PDO_W'(best_p2);
  end

`ifndef SYNTH
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |->
      (res.achieved_khz == '0 && res.chosen_feedback == '0 && !res.exact))
    else $error("empty result carries data");
  a_post_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.chosen_post2 <= res.chosen_post1)
    else $error("second post divider above first");
  a_wait_has_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_WAIT))
    else $error("divider issue not followed by wait");
`endif

endmodule

>>> src/pll_divider_search_core.sv
// top level of the pll divider search: config registers, input capture, result register
// depends on pds_pkg, pds_search and pds_divider
// the search walks all 305 feedback values and runs the divider on all 28 post divider pairs
// only for those feedback values whose vco is in the window
// the bit-serial divider (one quotient bit per cycle, 25 steps) sets the pace
// throughput: one request at a time; the next is taken while the last result waits
// reset: synchronous, restores register defaults and drops all valid flags
module pll_divider_search_core (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [pds_pkg::CIDX_W-1:0] cfg_index,
  input  logic [pds_pkg::CFG_W-1:0]  cfg_data,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pds_pkg::KHZ_W-1:0]  request_khz,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       found,
  output logic                       exact,
  output logic [pds_pkg::KHZ_W-1:0]  achieved_khz,
  output logic [pds_pkg::KHZ_W-1:0]  chosen_vco_khz,
  output logic [pds_pkg::FBO_W-1:0]  chosen_feedback,
  output logic [pds_pkg::PDO_W-1:0]  chosen_post1,
  output logic [pds_pkg::PDO_W-1:0]  chosen_post2
);
  import pds_pkg::*;

  cfg_t    cfg;
  logic    busy;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_q;

  // config registers; the user must only write them while no search runs, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_khz        <= REF_KHZ_RESET;
      cfg.vco_min_khz    <= VCO_MIN_RESET;
      cfg.vco_max_khz    <= VCO_MAX_RESET;
      cfg.prefer_low_vco <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_KHZ:   cfg.ref_khz        <= cfg_data[REF_W-1:0];
        CFG_VCO_MIN:   cfg.vco_min_khz    <= cfg_data[KHZ_W-1:0];
        CFG_VCO_MAX:   cfg.vco_max_khz    <= cfg_data[KHZ_W-1:0];
        CFG_PREFER_LO: cfg.prefer_low_vco <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // a new request starts as soon as the sequencer is free,
  // even if the previous result beat still sits in the output register
  assign in_ready = !busy;

  pds_search u_search (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (in_valid && in_ready),
    .request   (request_khz),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register takes the result when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign found           = out_q.found;
  assign exact           = out_q.exact;
  assign achieved_khz    = out_q.achieved_khz;
  assign chosen_vco_khz  = out_q.chosen_vco_khz;
  assign chosen_feedback = out_q.chosen_feedback;
  assign chosen_post1    = out_q.chosen_post1;
  assign chosen_post2    = out_q.chosen_post2;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> busy)
    else $error("request accepted but no search running");
  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(res_valid))
    else $error("result beat without a finished search");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_q)))
    else $error("pending result beat overwritten");
`endif

endmodule

>>> bench/tb.sv
// self-checking bench for pll_divider_search_core: directed and random frequency requests
// needs pds_pkg and the core; expected settings come from a behavioral search in this file
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pds_pkg::*;

  localparam int PERIOD_NS     = 12;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_REQ_KHZ   = 16000000;
  localparam int RAND_PHASES   = 9;
  localparam int PHASE_BEATS   = 10;
  localparam int HOLD_CYCLES   = 40000;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 2000;
  localparam int MAX_REPORTS   = 10;
  // the longest runs are two full 305-divider sweeps on the zero reference and two
  // 100-divider sweeps on the defaults; the rest use narrow windows
  localparam longint CYCLE_LIMIT = 10000000;

  // one request in flight together with the setting it should produce
  typedef struct packed {
    logic [KHZ_W-1:0] request;
    result_t          res;
  } answer_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              cfg_we      = 1'b0;
  logic [CIDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]  cfg_data    = '0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [KHZ_W-1:0]  request_khz = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic              found;
  logic              exact;
  logic [KHZ_W-1:0]  achieved_khz;
  logic [KHZ_W-1:0]  chosen_vco_khz;
  logic [FBO_W-1:0]  chosen_feedback;
  logic [PDO_W-1:0]  chosen_post1;
  logic [PDO_W-1:0]  chosen_post2;

  // bench copy of the register file, kept in step with every write
  logic [REF_W-1:0]  ref_khz_set = REF_KHZ_RESET;
  logic [KHZ_W-1:0]  vco_lo_set  = VCO_MIN_RESET;
  logic [KHZ_W-1:0]  vco_hi_set  = VCO_MAX_RESET;
  logic              upward_set  = 1'b0;

  logic [KHZ_W-1:0]  pending_q[$];   // requests not yet offered
  answer_t           answer_q[$];    // settings still owed by the core

  int     beats_in    = 0;
  int     beats_out   = 0;
  int     fail_count  = 0;
  int     pressure_at = -1;
  longint cycles      = 0;

  pll_divider_search_core DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .request_khz     (request_khz),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .exact           (exact),
    .achieved_khz    (achieved_khz),
    .chosen_vco_khz  (chosen_vco_khz),
    .chosen_feedback (chosen_feedback),
    .chosen_post1    (chosen_post1),
    .chosen_post2    (chosen_post2)
  );

  always #(PERIOD_NS / 2) clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // exhaustive search over feedback and post dividers for the current registers
  // ties go to the first candidate in search order, strict improvement only
  function automatic result_t best_setting(input logic [KHZ_W-1:0] target_khz);
    result_t         r;
    longint unsigned best_err;
    longint unsigned vco;
    longint unsigned khz;
    longint unsigned err;
    longint unsigned best_khz;
    longint unsigned best_vco;
    int              k;
    int              fb;
    int              p1;
    int              p2;
    int              best_p1;
    int              best_p2;
    r        = '0;
    best_err = ERROR_BOUND;
    best_khz = 0;
    best_vco = 0;
    best_p1  = 0;
    best_p2  = 0;
    for (k = 0; k <= FEEDBACK_MAX - FEEDBACK_MIN; k++) begin
      fb  = upward_set ? FEEDBACK_MIN + k : FEEDBACK_MAX - k;
      vco = longint'(fb) * longint'(ref_khz_set);
      // feedback values outside the vco window are skipped entirely
      if (vco >= vco_lo_set && vco <= vco_hi_set) begin
        for (p1 = POST_DIV_MAX; p1 >= 1; p1--) begin
          for (p2 = p1; p2 >= 1; p2--) begin
            khz = vco / longint'(p1 * p2);
            err = (khz >= target_khz) ? khz - target_khz : target_khz - khz;
            if (err < best_err) begin
              best_err          = err;
              best_khz          = khz;
              best_vco          = vco;
              best_p1           = p1;
              best_p2           = p2;
              r.found           = 1'b1;
              r.achieved_khz    = khz[KHZ_W-1:0];
              r.chosen_vco_khz  = vco[KHZ_W-1:0];
              r.chosen_feedback = FBO_W'(fb);
              r.chosen_post1    = PDO_W'(p1);
              r.chosen_post2    = PDO_W'(p2);
            end
          end
        end
      end
    end
    // exact only when the output hits the request and the division left no remainder
    r.exact = r.found && (best_khz == target_khz) &&
              (best_khz * longint'(best_p1) * longint'(best_p2) == best_vco);
    return r;
  endfunction

  // idle length: half the time none, mostly short, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // accepted request beat: work out the setting it must produce
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      answer_q.push_back('{request: request_khz, res: best_setting(request_khz)});
      beats_in++;
    end
  end

  // offer requests on the falling edge; hold the beat until it is taken
  always @(negedge clk) begin
    int beats_seen;
    int gap_left;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && beats_in == beats_seen) begin
      // still waiting on the core, keep valid and payload steady
    end else begin
      if (in_valid) begin
        beats_seen = beats_in;
        gap_left   = pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        request_khz <= pending_q.pop_front();
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // accepted result beat: compare every field with the oldest owed setting
  always @(posedge clk) begin
    result_t got;
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      got = {found, exact, achieved_khz, chosen_vco_khz,
             chosen_feedback, chosen_post1, chosen_post2};
      beats_out++;
      if (answer_q.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("[%0t] result beat with no request outstanding: found=%0b khz=%0d",
                   $realtime, got.found, got.achieved_khz);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (got !== want.res) begin
          if (fail_count < MAX_REPORTS) begin
            $display("[%0t] mismatch for %0d kHz: expected found=%0b exact=%0b khz=%0d vco=%0d fb=%0d p1=%0d p2=%0d",
                     $realtime, want.request, want.res.found, want.res.exact,
                     want.res.achieved_khz, want.res.chosen_vco_khz,
                     want.res.chosen_feedback, want.res.chosen_post1,
                     want.res.chosen_post2);
            $display("    actual found=%0b exact=%0b khz=%0d vco=%0d fb=%0d p1=%0d p2=%0d",
                     got.found, got.exact, got.achieved_khz, got.chosen_vco_khz,
                     got.chosen_feedback, got.chosen_post1, got.chosen_post2);
          end
          fail_count++;
        end
      end
    end
  end

  // ready on the falling edge: a random stall drawn per result beat, plus one long
  // hold-off so the core fills up behind a waiting result and drops in_ready
  always @(negedge clk) begin
    int drawn_for;
    int stall_left;
    int hold_left;
    bit pressure_done;
    if (rst) begin
      out_ready <= 1'b0;
      drawn_for  = -1;
    end else begin
      if (!pressure_done && pressure_at >= 0 && beats_in >= pressure_at) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES;
      end
      if (out_valid && drawn_for != beats_out) begin
        drawn_for  = beats_out;
        stall_left = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  // registers only move while nothing is queued, offered or owed
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers; unused upper data bits carry junk on the narrow ones
  task automatic load_setup(input logic [REF_W-1:0] rk, input logic [KHZ_W-1:0] lo,
                            input logic [KHZ_W-1:0] hi, input logic up);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REF_KHZ;
    cfg_data  <= {(CFG_W - REF_W)'($urandom), rk};
    @(negedge clk);
    cfg_index <= CFG_VCO_MIN;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= CFG_VCO_MAX;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_index <= CFG_PREFER_LO;
    cfg_data  <= {(CFG_W - 1)'($urandom), up};
    @(negedge clk);
    cfg_we      <= 1'b0;
    ref_khz_set  = rk;
    vco_lo_set   = lo;
    vco_hi_set   = hi;
    upward_set   = up;
  endtask

  initial begin
    int ph;
    int n;
    int fb;
    int fb_lo;
    int fb_hi;
    int p1;
    int p2;
    int rk;
    int target;
    int lo;
    int hi;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: window holds feedback 34..133, searched downward
    pending_q.push_back(24'd0);
    pending_q.push_back(24'd48000);

    // zero reference: every vco is 0 and all 305 dividers qualify; error of exactly
    // the bound must not count as found
    wait_idle();
    load_setup(16'd0, 24'd0, 24'hFFFFFF, 1'b1);
    pending_q.push_back(24'd0);
    pending_q.push_back(24'd100000);

    // largest reference at the top of the vco range, feedback 250..256
    wait_idle();
    load_setup(16'hFFFF, 24'd16383750, 24'hFFFFFF, 1'b0);
    pending_q.push_back(24'(MAX_REQ_KHZ));
    pending_q.push_back(24'd234362);   // one past the error bound below the lowest output
    pending_q.push_back(24'd234363);   // just inside it
    pending_q.push_back(24'd589815);   // 65535*252 / 28, even division
    pending_q.push_back(24'd1381696);  // 65535*253 / 12, truncated

    // inverted vco window: nothing can be found
    wait_idle();
    load_setup(16'd12000, 24'd1600000, 24'd400000, 1'b1);
    pending_q.push_back(24'd48000);
    pending_q.push_back(24'd0);

    // one-point window at the top feedback value: ties between post divider pairs,
    // exact hit and a truncated one
    wait_idle();
    load_setup(16'd50000, 24'd16000000, 24'd16000000, 1'b1);
    pending_q.push_back(24'd16000000);
    pending_q.push_back(24'd326530);
    pending_q.push_back(24'd4000000);

    // random part: narrow windows keep each search short; most requests sit on or
    // near a reachable output, the rest are spread over the whole field
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      rk    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 50000);
      fb_lo = $urandom_range(FEEDBACK_MIN, FEEDBACK_MAX);
      fb_hi = fb_lo + $urandom_range(0, 5);
      if (fb_hi > FEEDBACK_MAX) fb_hi = FEEDBACK_MAX;
      lo = fb_lo * rk - int'($urandom_range(0, rk - 1));
      hi = fb_hi * rk + int'($urandom_range(0, rk - 1));
      load_setup(REF_W'(rk), KHZ_W'(lo), KHZ_W'(hi), 1'($urandom_range(0, 1)));
      if (ph == 0) pressure_at = beats_in + 2;
      for (n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          target = $urandom_range(0, MAX_REQ_KHZ);
        end else begin
          fb     = $urandom_range(fb_lo, fb_hi);
          p1     = $urandom_range(1, POST_DIV_MAX);
          p2     = $urandom_range(1, p1);
          target = (fb * rk) / (p1 * p2);
          case ($urandom_range(0, 3))
            0, 1: ;  // right on a reachable output
            2: target += int'($urandom_range(0, 6)) - 3;
            default: target += int'($urandom_range(0, 300000)) - 150000;
          endcase
          if (target < 0) target = 0;
          if (target > MAX_REQ_KHZ) target = MAX_REQ_KHZ;
        end
        pending_q.push_back(KHZ_W'(target));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
src/pds_pkg.sv
src/pds_divider.sv
src/pds_search.sv
src/pll_divider_search_core.sv
bench/tb.sv
